FILE: design/ckb_pkg.sv
// Shared types and constants for the color-key sprite blitter.
// Holds the register index codes, the field widths and the configuration bundle.
// No dependencies.
`default_nettype none

package ckb_pkg;

   // Default limits, used as module parameter defaults
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_STRIDE_DEF = 1024;

   // Widths that cover the whole parameter range (up to 4096 / 8192)
   localparam int DIM_W    = 13;
   localparam int STRIDE_W = 14;

   localparam int PIXEL_W  = 8;
   localparam int ADDR_W   = 18;
   localparam int COUNT_W  = 17;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 11;

   localparam int WIDTH_REG_W  = 9;
   localparam int HEIGHT_REG_W = 9;
   localparam int STRIDE_REG_W = 11;

   localparam logic [PIXEL_W-1:0] KEY_RESET = 8'd10;

   localparam int RSP_DATA_W = 64;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SPRITE_WIDTH    = 3'd0,
      CSR_SPRITE_HEIGHT   = 3'd1,
      CSR_DEST_STRIDE     = 3'd2,
      CSR_TRANSPARENT_KEY = 3'd3,
      CSR_MIRROR          = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    width_m1;
      logic [DIM_W-1:0]    height_m1;
      logic [STRIDE_W-1:0] stride;
      logic [PIXEL_W-1:0]  key;
      logic                mirror;
      logic                config_error;
      logic                restart;
   } cfg_type;

endpackage : ckb_pkg

`default_nettype wire

FILE: design/ckb_cfg.sv
// Configuration registers of the sprite blitter: clamp and hold the settings.
// Depends on ckb_pkg for the register codes and the cfg_type bundle.
`default_nettype none

module ckb_cfg
   import ckb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int MAX_STRIDE = MAX_STRIDE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [PIXEL_W-1:0]  key_ff, key_in;
   logic                mirror_ff, mirror_in;
   logic                known_index;

   logic [DIM_W-1:0]    width_clamp;
   logic [DIM_W-1:0]    height_clamp;
   logic [STRIDE_W-1:0] stride_clamp;
   logic [DIM_W-1:0]    width_raw;
   logic [DIM_W-1:0]    height_raw;
   logic [STRIDE_W-1:0] stride_raw;

   // Zero means one; saturate above the configured maximum
   always_comb begin
      width_raw  = DIM_W'(csr_wdata[WIDTH_REG_W-1:0]);
      height_raw = DIM_W'(csr_wdata[HEIGHT_REG_W-1:0]);
      stride_raw = STRIDE_W'(csr_wdata[STRIDE_REG_W-1:0]);

      if (width_raw == '0) begin
         width_clamp = DIM_W'(1);
      end else if (width_raw > DIM_W'(MAX_WIDTH)) begin
         width_clamp = DIM_W'(MAX_WIDTH);
      end else begin
         width_clamp = width_raw;
      end

      if (height_raw == '0) begin
         height_clamp = DIM_W'(1);
      end else if (height_raw > DIM_W'(MAX_HEIGHT)) begin
         height_clamp = DIM_W'(MAX_HEIGHT);
      end else begin
         height_clamp = height_raw;
      end

      if (stride_raw == '0) begin
         stride_clamp = STRIDE_W'(1);
      end else if (stride_raw > STRIDE_W'(MAX_STRIDE)) begin
         stride_clamp = STRIDE_W'(MAX_STRIDE);
      end else begin
         stride_clamp = stride_raw;
      end
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      stride_in   = stride_ff;
      key_in      = key_ff;
      mirror_in   = mirror_ff;
      known_index = 1'b1;
      case (csr_index_type'(csr_addr))
         CSR_SPRITE_WIDTH:    width_in  = width_clamp;
         CSR_SPRITE_HEIGHT:   height_in = height_clamp;
         CSR_DEST_STRIDE:     stride_in = stride_clamp;
         CSR_TRANSPARENT_KEY: key_in    = csr_wdata[PIXEL_W-1:0];
         CSR_MIRROR:          mirror_in = csr_wdata[0];
         default:             known_index = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         stride_ff <= STRIDE_W'(1);
         key_ff    <= KEY_RESET;
         mirror_ff <= 1'b0;
      end else if (csr_we) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         key_ff    <= key_in;
         mirror_ff <= mirror_in;
      end
   end

   always_comb begin
      cfg.width_m1     = width_ff - DIM_W'(1);
      cfg.height_m1    = height_ff - DIM_W'(1);
      cfg.stride       = stride_ff;
      cfg.key          = key_ff;
      cfg.mirror       = mirror_ff;
      cfg.config_error = stride_ff < STRIDE_W'(width_ff);
      cfg.restart      = csr_we && known_index;
   end

endmodule : ckb_cfg

`default_nettype wire

FILE: design/color_key_sprite_blit_with_flip.sv
// Top level of the color-key sprite blitter with horizontal flip.
// Depends on ckb_pkg and ckb_cfg.
`default_nettype none

// Streams source sprite pixels in row-major order, one per transaction on the
// req_ side, and returns one write transaction per pixel on the rsp_ side: the
// destination byte address (row base plus column, or plus width-1-column when
// mirrored), the pixel, a write enable that drops for the transparent key or
// when the stride is below the width, running write and skip counts, and
// tlast on the final pixel of the sprite. Row base grows by the stride at the
// end of each row, so no multiplier is involved. Throughput is one pixel per
// clock unless rsp_tready stalls; rsp_tvalid rises the cycle after acceptance.
// req_tready stays high while the single result register is empty or being
// drained in the same cycle. Any write to a known configuration register
// restarts the sprite; write configuration only while idle.
module color_key_sprite_blit_with_flip
   import ckb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int MAX_STRIDE = MAX_STRIDE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // source pixels
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIXEL_W-1:0]    req_tdata,   // [7:0] pixel_in
   // destination writes
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [17:0] dest_addr, [25:18] pixel_out,
                                                   // [26] write_enable,
                                                   // [43:27] writes_so_far,
                                                   // [60:44] skips_so_far,
                                                   // [61] config_error, [63:62] zero
   output logic                       rsp_tlast,   // last pixel of the sprite
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   cfg_type cfg;

   ckb_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_STRIDE (MAX_STRIDE)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sprite walk state
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  row_base_ff, row_base_in;
   logic [COUNT_W-1:0] writes_ff, writes_in;
   logic [COUNT_W-1:0] skips_ff, skips_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic [PIXEL_W-1:0] pixel_ff;
   logic               we_ff, we_in;
   logic               last_ff;
   logic               err_ff;

   logic               accept;
   logic [COL_W-1:0]   width_m1;
   logic [ROW_W-1:0]   height_m1;
   logic [COL_W-1:0]   col_sel;
   logic [ADDR_W-1:0]  addr_in;
   logic               end_row;
   logic               last_in;
   logic               is_key;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign width_m1  = cfg.width_m1[COL_W-1:0];
   assign height_m1 = cfg.height_m1[ROW_W-1:0];

   always_comb begin
      end_row = col_ff >= width_m1;
      last_in = end_row && (row_ff >= height_m1);
      // mirrored rows walk from the right edge
      col_sel = cfg.mirror ? (width_m1 - col_ff) : col_ff;
      addr_in = row_base_ff + ADDR_W'(col_sel);
      is_key  = req_tdata == cfg.key;

      we_in     = 1'b0;
      writes_in = writes_ff;
      skips_in  = skips_ff;
      if (!cfg.config_error) begin
         if (is_key) begin
            skips_in = skips_ff + COUNT_W'(1);
         end else begin
            writes_in = writes_ff + COUNT_W'(1);
            we_in     = 1'b1;
         end
      end

      col_in      = col_ff + COL_W'(1);
      row_in      = row_ff;
      row_base_in = row_base_ff;
      if (last_in) begin
         col_in      = '0;
         row_in      = '0;
         row_base_in = '0;
         writes_in   = '0;
         skips_in    = '0;
      end else if (end_row) begin
         col_in      = '0;
         row_in      = row_ff + ROW_W'(1);
         row_base_in = row_base_ff + ADDR_W'(cfg.stride);
      end
   end

   // Advance the walk on each accepted pixel; a register write restarts it
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         col_ff      <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
         writes_ff   <= '0;
         skips_ff    <= '0;
      end else if (accept) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         row_base_ff <= row_base_in;
         writes_ff   <= writes_in;
         skips_ff    <= skips_in;
      end
   end

   // Counts reported with the pixel include the pixel itself
   logic [COUNT_W-1:0] writes_rpt_ff;
   logic [COUNT_W-1:0] skips_rpt_ff;
   logic [COUNT_W-1:0] writes_rpt_in;
   logic [COUNT_W-1:0] skips_rpt_in;

   always_comb begin
      writes_rpt_in = writes_ff;
      skips_rpt_in  = skips_ff;
      if (!cfg.config_error) begin
         if (is_key) begin
            skips_rpt_in = skips_ff + COUNT_W'(1);
         end else begin
            writes_rpt_in = writes_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register; hold it while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff       <= addr_in;
         pixel_ff      <= req_tdata;
         we_ff         <= we_in;
         writes_rpt_ff <= writes_rpt_in;
         skips_rpt_ff  <= skips_rpt_in;
         last_ff       <= last_in;
         err_ff        <= cfg.config_error;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {2'b00, err_ff, skips_rpt_ff, writes_rpt_ff, we_ff, pixel_ff, addr_ff};

`ifndef SYNTHESIS
   // A suppressed write never carries an enable
   a_err_blocks_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[61] |-> !rsp_tdata[26])
      else $error("write enable asserted with config error");

   // Column counter never runs past the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= width_m1)
      else $error("column counter past sprite width");

   // Last pixel restarts the walk
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last_in |=> col_ff == '0 && row_ff == '0 && row_base_ff == '0
         && writes_ff == '0 && skips_ff == '0)
      else $error("sprite state not cleared after last pixel");

   // An accepted pixel always yields a valid result in the result register
   a_valid_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted pixel produced no result");
`endif

endmodule : color_key_sprite_blit_with_flip

`default_nettype wire
